@@ rtl/stable_time_sort_engine_assert.svh @@
// Assertion macros shared by the stable time sort engine.
`ifndef STABLE_TIME_SORT_ENGINE_ASSERT_SVH
`define STABLE_TIME_SORT_ENGINE_ASSERT_SVH

// Check that a condition never holds while out of reset.
`define STSE_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sort engine check failed");

// Check that an antecedent is followed by a consequent in the next cycle.
`define STSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sort engine check failed");

`endif

@@ rtl/stse_pkg.sv @@
// Shared constants and controller/datapath interface types of the sort engine.
`timescale 1ns / 1ps
package stse_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 64;
    localparam int TIME_W      = 64;
    localparam int TAG_W       = 6;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int S_DATA_W    = ((TIME_W + TAG_W + 7) / 8) * 8;
    localparam int M_DATA_W    = ((TAG_W + TIME_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SORT_BY_TIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ORDER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS_REORDER = 2'd2;

    typedef logic signed [KEY_BITS-1:0] key_t;
    typedef logic signed [TIME_W-1:0]   time_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;          // write accepted request into the store
        logic scan_start;    // restart a selection pass
        logic scan_step;     // advance the selection pass
        logic direct_rd;     // address the store at the output position
        logic out_load_best; // move selected entry to the output register
        logic out_load_rd;   // move read data to the output register
        logic pos_adv;       // advance the output position
        logic run_done;      // clear run state after the final result
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic sorted;    // time ordering in effect
        logic scan_done; // selection pass finished, best entry is final
        logic out_last;  // output register holds the final result
    } dp_status_t;

endpackage

@@ rtl/stse_ctrl.sv @@
// Controller state machine of the sort engine: load, select, emit.
`timescale 1ns / 1ps
module stse_ctrl
    import stse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DRD  = 3'd2;
    localparam logic [2:0] ST_DOUT = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        if (status.sorted)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_DRD;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    cmd.out_load_best = 1'b1;
                    state_next        = ST_HOLD;
                end
            end
            ST_DRD:
            begin
                cmd.direct_rd = 1'b1;
                state_next    = ST_DOUT;
            end
            ST_DOUT:
            begin
                cmd.out_load_rd = 1'b1;
                state_next      = ST_HOLD;
            end
            ST_HOLD:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        cmd.run_done = 1'b1;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        cmd.pos_adv = 1'b1;
                        if (status.sorted)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_DRD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

@@ rtl/stse_datapath.sv @@
// Datapath of the sort engine: entry store, selection pass, output register.
`timescale 1ns / 1ps
module stse_datapath
    import stse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  logic [TIME_W-1:0]    in_time,
    input  logic [TAG_W-1:0]     in_tag,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic [TAG_W-1:0]     out_tag,
    output logic [TIME_W-1:0]    out_time,
    output logic                 out_last,
    output logic                 out_ovf
);

    // Configuration registers
    logic sort_reg;
    logic rev_reg;
    logic supp_reg;
    logic sorted;
    logic rev_eff;

    // Entry store
    logic [KEY_BITS-1:0] time_mem [MAX_ENTRIES];
    logic [TAG_W-1:0]    tag_mem  [MAX_ENTRIES];
    logic [KEY_BITS-1:0] rd_time_reg;
    logic [TAG_W-1:0]    rd_tag_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;

    // Run state
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [MAX_ENTRIES-1:0] emitted_reg, emitted_next;
    logic [CNT_W-1:0]       direct_pos;

    // Selection pass
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                cand_vld_reg, cand_vld_next;
    logic [IDX_W-1:0]    cand_idx_reg;
    logic                best_vld_reg, best_vld_next;
    logic [KEY_BITS-1:0] best_time_reg;
    logic [TAG_W-1:0]    best_tag_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                take;
    logic                better;

    // Output register
    logic [KEY_BITS-1:0] out_key_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic                out_last_reg;
    logic                out_ovf_reg;

    assign sorted  = sort_reg & ~supp_reg;
    assign rev_eff = rev_reg & ~supp_reg;

    // Capture configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_reg <= 1'b0;
            rev_reg  <= 1'b0;
            supp_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SORT_BY_TIME:     sort_reg <= cfg_data;
                CFG_REVERSE_ORDER:    rev_reg  <= cfg_data;
                CFG_SUPPRESS_REORDER: supp_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Store write address is the fill count; full store drops the request
    assign wr_en = cmd.load && (count_reg < CNT_W'(MAX_ENTRIES));

    // Output position in arrival order, mirrored when reversing
    assign direct_pos = rev_eff ? (count_reg - pos_reg - CNT_W'(1)) : pos_reg;
    assign rd_addr    = cmd.direct_rd ? direct_pos[IDX_W-1:0] : scan_reg[IDX_W-1:0];

    // Write and read the store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[count_reg[IDX_W-1:0]] <= in_time[KEY_BITS-1:0];
            tag_mem[count_reg[IDX_W-1:0]]  <= in_tag;
        end
        rd_time_reg <= time_mem[rd_addr];
        rd_tag_reg  <= tag_mem[rd_addr];
    end

    // Newest first keeps the earliest of equal keys; reversed keeps the latest
    assign better = rev_eff ? (key_t'(rd_time_reg) <= key_t'(best_time_reg))
                            : (key_t'(rd_time_reg) >  key_t'(best_time_reg));
    assign take   = cmd.scan_step && cand_vld_reg && !emitted_reg[cand_idx_reg]
                    && (!best_vld_reg || better);

    // Next values of run and selection state
    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        emitted_next  = emitted_reg;
        scan_next     = scan_reg;
        cand_vld_next = cand_vld_reg;
        best_vld_next = best_vld_reg;

        if (cmd.load)
        begin
            if (wr_en)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.scan_start)
        begin
            scan_next     = '0;
            cand_vld_next = 1'b0;
            best_vld_next = 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_reg < count_reg)
            begin
                scan_next     = scan_reg + CNT_W'(1);
                cand_vld_next = 1'b1;
            end
            else
            begin
                cand_vld_next = 1'b0;
            end
            if (take)
            begin
                best_vld_next = 1'b1;
            end
        end

        if (cmd.out_load_best)
        begin
            emitted_next[best_idx_reg] = 1'b1;
        end

        if (cmd.pos_adv)
        begin
            pos_next = pos_reg + CNT_W'(1);
        end

        if (cmd.run_done)
        begin
            count_next   = '0;
            ovf_next     = 1'b0;
            pos_next     = '0;
            emitted_next = '0;
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            emitted_reg  <= '0;
            scan_reg     <= '0;
            cand_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            pos_reg      <= pos_next;
            emitted_reg  <= emitted_next;
            scan_reg     <= scan_next;
            cand_vld_reg <= cand_vld_next;
            best_vld_reg <= best_vld_next;
            if (cmd.out_load_best || cmd.out_load_rd)
            begin
                out_last_reg <= (pos_reg + CNT_W'(1)) == count_reg;
            end
        end
    end

    // Hold candidate index and best entry of the pass
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            cand_idx_reg <= scan_reg[IDX_W-1:0];
        end
        if (take)
        begin
            best_time_reg <= rd_time_reg;
            best_tag_reg  <= rd_tag_reg;
            best_idx_reg  <= cand_idx_reg;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_best)
        begin
            out_key_reg <= best_time_reg;
            out_tag_reg <= best_tag_reg;
            out_ovf_reg <= ovf_reg;
        end
        else if (cmd.out_load_rd)
        begin
            out_key_reg <= rd_time_reg;
            out_tag_reg <= rd_tag_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign status.sorted    = sorted;
    assign status.scan_done = (scan_reg == count_reg) && !cand_vld_reg;
    assign status.out_last  = out_last_reg;

    assign out_tag  = out_tag_reg;
    assign out_time = TIME_W'(key_t'(out_key_reg));
    assign out_last = out_last_reg;
    assign out_ovf  = out_ovf_reg;

endmodule

@@ rtl/stable_time_sort_engine.sv @@
// Top level of the stable time sort engine.
// Usage:
//   Input stream (s_*): one directory entry per request, tdata carries the
//   timestamp and tag, tlast closes the set. Entries are taken one per cycle
//   until tlast; beyond 64 entries they are dropped and the run is flagged.
//   Output stream (m_*): after tlast the set leaves as a run, one request per
//   entry; tlast marks the final entry, tuser is set on every entry of a run
//   that dropped entries. The input is not ready while a run drains.
//   Configuration: cfg_we/cfg_index/cfg_data write sort_by_time (0),
//   reverse_order (1) and suppress_reorder (2); write only between runs.
//   In arrival or reversed arrival order each result goes through a store
//   read, an output load and a hand-off. With time ordering each result is
//   chosen by one pass over the single-read-port entry store. A stalled
//   receiver holds the output register and the engine waits.
//   Reset clears the configuration, the fill count and the overflow flag,
//   and leaves the engine ready for a new set.
`timescale 1ns / 1ps
module stable_time_sort_engine
    import stse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // time_key[63:0], entry_tag[69:64], zero pad
    input  logic                 s_tlast,   // last_item
    // Output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // out_tag[5:0], out_time[69:6], zero pad
    output logic                 m_tlast,   // last_out
    output logic                 m_tuser    // overflowed
);

    `include "stable_time_sort_engine_assert.svh"

    ctrl_cmd_t          cmd;
    dp_status_t         status;
    logic [TAG_W-1:0]   out_tag;
    logic [TIME_W-1:0]  out_time;

    stse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    stse_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_time   (s_tdata[TIME_W-1:0]),
        .in_tag    (s_tdata[TIME_W+TAG_W-1:TIME_W]),
        .cmd       (cmd),
        .status    (status),
        .out_tag   (out_tag),
        .out_time  (out_time),
        .out_last  (m_tlast),
        .out_ovf   (m_tuser)
    );

    // Pack output fields, tag lowest
    assign m_tdata = M_DATA_W'({out_time, out_tag});

    // Checks
    `STSE_ASSERT_NEVER(a_no_load_while_draining, s_tready && m_tvalid)
    `STSE_ASSERT_NEXT(a_last_in_stops_load, s_tvalid && s_tready && s_tlast, !s_tready)
    `STSE_ASSERT_NEXT(a_run_end_reopens, m_tvalid && m_tready && m_tlast, s_tready)

endmodule

@@ dv/stable_time_sort_engine_tb.sv @@
// Self-checking testbench for the stable time sort engine: directed sets, then random sets.
`timescale 1ns / 1ps
module stable_time_sort_engine_tb;
    import stse_pkg::*;

    // Mode word: bit 0 sort_by_time, bit 1 reverse_order, bit 2 suppress_reorder
    localparam logic [2:0] MODE_ARRIVAL  = 3'b000;
    localparam logic [2:0] MODE_TIME     = 3'b001;
    localparam logic [2:0] MODE_REVERSE  = 3'b010;
    localparam logic [2:0] MODE_TIME_REV = 3'b011;
    localparam logic [2:0] MODE_SUPPRESS = 3'b111;

    // Index past the last register; the engine ignores writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [63:0] KEY_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] KEY_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_NEG1 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_NEG8 = 64'hFFFF_FFFF_FFFF_FFF8;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int DIR_ROWS      = 20;

    typedef struct packed {
        logic [5:0]  tag;
        logic [63:0] tkey;
        logic        last;
        logic        ovf;
    } dir_result_t;

    typedef struct packed {
        logic        new_modes;
        logic [2:0]  modes;
        logic [63:0] tkey;
        logic [5:0]  tag;
        logic        last;
        logic        typed;
        logic [5:0]  exp_tag;
        logic [63:0] exp_time;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    // Predictor state: entry store, fill count, drop flag and modes
    key_t       stored_time [MAX_ENTRIES];
    logic [5:0] stored_tag  [MAX_ENTRIES];
    int         fill_count = 0;
    logic       dropped = 1'b0;
    logic       mode_sort = 1'b0;
    logic       mode_reverse = 1'b0;
    logic       mode_suppress = 1'b0;

    dir_result_t expected_listing [$];
    int          mismatches = 0;
    bit          hold_armed = 1'b0;

    // Directed sets: single entries after reset with typed results, then
    // stability, reversal and suppression checks left to the predictor
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{1'b0, MODE_ARRIVAL,  64'h0,    6'd0,  1'b1, 1'b1, 6'd0,  64'h0},
        '{1'b0, MODE_ARRIVAL,  KEY_MAX,  6'd63, 1'b1, 1'b1, 6'd63, KEY_MAX},
        '{1'b0, MODE_ARRIVAL,  KEY_MIN,  6'd42, 1'b1, 1'b1, 6'd42, KEY_MIN},
        '{1'b0, MODE_ARRIVAL,  KEY_NEG1, 6'd21, 1'b1, 1'b1, 6'd21, KEY_NEG1},
        '{1'b1, MODE_TIME,     64'd5,    6'd1,  1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_TIME,     KEY_MIN,  6'd2,  1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_TIME,     64'd5,    6'd3,  1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_TIME,     KEY_MAX,  6'd4,  1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_TIME,     KEY_NEG1, 6'd5,  1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_TIME,     64'd5,    6'd6,  1'b1, 1'b0, 6'd0,  64'h0},
        '{1'b1, MODE_TIME_REV, 64'd3,    6'd7,  1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_TIME_REV, 64'd3,    6'd8,  1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_TIME_REV, 64'd7,    6'd9,  1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_TIME_REV, KEY_NEG8, 6'd10, 1'b1, 1'b0, 6'd0,  64'h0},
        '{1'b1, MODE_REVERSE,  64'd10,   6'd11, 1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_REVERSE,  64'd20,   6'd12, 1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_REVERSE,  64'd30,   6'd13, 1'b1, 1'b0, 6'd0,  64'h0},
        '{1'b1, MODE_SUPPRESS, 64'd1,    6'd14, 1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_SUPPRESS, 64'd9,    6'd15, 1'b0, 1'b0, 6'd0,  64'h0},
        '{1'b0, MODE_SUPPRESS, 64'd5,    6'd16, 1'b1, 1'b0, 6'd0,  64'h0}
    };

    stable_time_sort_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Store one accepted entry; on the closing entry, order the set and queue the run
    function automatic void record_entry(input logic [63:0] tkey, input logic [5:0] tag,
                                         input logic last);
        int rank [MAX_ENTRIES];
        int count;
        int i;
        int j;
        int held;
        if (fill_count < MAX_ENTRIES)
        begin
            stored_time[fill_count] = tkey;
            stored_tag[fill_count]  = tag;
            fill_count++;
        end
        else
            dropped = 1'b1;
        if (!last)
            return;
        count = fill_count;
        for (i = 0; i < count; i++)
            rank[i] = i;
        if (!mode_suppress)
        begin
            // Stable newest-first: shift only past strictly older entries
            if (mode_sort)
            begin
                for (i = 1; i < count; i++)
                begin
                    held = rank[i];
                    j = i;
                    while (j > 0 && stored_time[held] > stored_time[rank[j-1]])
                    begin
                        rank[j] = rank[j-1];
                        j--;
                    end
                    rank[j] = held;
                end
            end
            if (mode_reverse)
            begin
                for (i = 0; i < count / 2; i++)
                begin
                    held = rank[i];
                    rank[i] = rank[count-1-i];
                    rank[count-1-i] = held;
                end
            end
        end
        for (i = 0; i < count; i++)
            expected_listing.push_back('{stored_tag[rank[i]], stored_time[rank[i]],
                                         (i == count - 1), dropped});
        fill_count = 0;
        dropped = 1'b0;
    endfunction

    // Draw a key: full-range, a narrow band that forces ties, or an extreme
    function automatic logic [63:0] pick_key(input bit ties);
        int unsigned roll;
        int          narrow;
        roll = $urandom_range(0, 9);
        if ((ties && roll < 7) || (!ties && roll < 2))
        begin
            narrow = int'($urandom_range(0, 6)) - 3;
            return {{32{narrow[31]}}, narrow};
        end
        if (roll == 9)
        begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return 64'h0;
                default: return KEY_NEG1;
            endcase
        end
        return {$urandom, $urandom};
    endfunction

    // Wait until the engine is idle, then write every register
    task automatic program_modes(input logic [2:0] modes);
        s_tvalid <= 1'b0;
        while (expected_listing.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SORT_BY_TIME;
        cfg_data  <= modes[0];
        @(posedge clk);
        cfg_index <= CFG_REVERSE_ORDER;
        cfg_data  <= modes[1];
        @(posedge clk);
        cfg_index <= CFG_SUPPRESS_REORDER;
        cfg_data  <= modes[2];
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 1'($urandom_range(0, 1));
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_sort     = modes[0];
        mode_reverse  = modes[1];
        mode_suppress = modes[2];
    endtask

    // Offer one entry, after a random gap unless calm, and hold it until accepted
    task automatic send_entry(input logic [63:0] tkey, input logic [5:0] tag,
                              input logic last, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, tag, tkey};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_random_set(input int size, input bit ties);
        bit          calm;
        int          k;
        logic [63:0] tkey;
        logic [5:0]  tag;
        calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < size; k++)
        begin
            tkey = pick_key(ties);
            tag  = 6'($urandom_range(0, 63));
            send_entry(tkey, tag, (k == size - 1), calm);
            record_entry(tkey, tag, (k == size - 1));
        end
    endtask

    // Stimulus
    initial
    begin
        int       row;
        int       phase;
        int       set_no;
        dir_row_t step;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (row = 0; row < DIR_ROWS; row++)
        begin
            step = directed_rows[row];
            if (step.new_modes)
                program_modes(step.modes);
            send_entry(step.tkey, step.tag, step.last, 1'b0);
            if (step.typed)
                expected_listing.push_back('{step.exp_tag, step.exp_time, 1'b1, 1'b0});
            else
                record_entry(step.tkey, step.tag, step.last);
        end

        // Random sets across all mode settings, with a full set and an overflow
        for (phase = 0; phase < 10; phase++)
        begin
            program_modes(phase < 8 ? 3'(phase) : 3'($urandom_range(0, 7)));
            for (set_no = 0; set_no < 4; set_no++)
            begin
                if (phase == 5 && set_no == 1)
                    hold_armed = 1'b1;
                send_random_set($urandom_range(1, 7), 1'($urandom_range(0, 1)));
            end
            if (phase == 1)
                send_random_set(MAX_ENTRIES, 1'b1);
            if (phase == 3)
                send_random_set(MAX_ENTRIES + 2, 1'b0);
        end
        s_tvalid <= 1'b0;

        while (expected_listing.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        $display("%0t mismatch on %s: expected %h, actual %h", $time, field, want, got);
        mismatches++;
    endtask

    // Result receiver: random stalls, one long hold-off, and checking
    initial
    begin
        int          wait_cnt;
        int          hold_cnt;
        int          taken;
        bit          calm;
        dir_result_t got;
        dir_result_t want;
        wait_cnt = 0;
        hold_cnt = 0;
        taken = 0;
        calm = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = '{m_tdata[5:0], m_tdata[69:6], m_tlast, m_tuser};
                if (expected_listing.size() == 0)
                begin
                    $display("%0t unexpected request: expected none, actual tag %h time %h",
                             $time, got.tag, got.tkey);
                    mismatches++;
                end
                else
                begin
                    want = expected_listing.pop_front();
                    if (got.tag !== want.tag)
                        flag_mismatch("out_tag", 64'(want.tag), 64'(got.tag));
                    if (got.tkey !== want.tkey)
                        flag_mismatch("out_time", want.tkey, got.tkey);
                    if (got.last !== want.last)
                        flag_mismatch("last_out", 64'(want.last), 64'(got.last));
                    if (got.ovf !== want.ovf)
                        flag_mismatch("overflowed", 64'(want.ovf), 64'(got.ovf));
                end
                taken++;
                // Switch between stalling and full-rate stretches now and then
                if (taken % 24 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                wait_cnt = calm ? 0 : $urandom_range(0, 7);
                if (hold_armed)
                begin
                    hold_cnt = HOLD_CYCLES;
                    hold_armed = 1'b0;
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (wait_cnt > 0)
            begin
                wait_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        #(2_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/stse_pkg.sv
rtl/stse_ctrl.sv
rtl/stse_datapath.sv
rtl/stable_time_sort_engine.sv
dv/stable_time_sort_engine_tb.sv
